>>> rtl/cvfp_pkg.sv
`timescale 1ns / 1ps

package cvfp_pkg;

  // Field widths
  localparam int unsigned ByteW  = 8;
  localparam int unsigned ChanW  = 2;
  localparam int unsigned MantW  = 30;
  localparam int unsigned FracW  = 4;
  localparam int unsigned ActW   = 3;
  localparam int unsigned HistN  = 4;

  // Character codes
  localparam logic [ByteW-1:0] CH_MARK  = 8'h56;  // 'V'
  localparam logic [ByteW-1:0] CH_DOT   = 8'h2E;  // '.'
  localparam logic [ByteW-1:0] CH_COMMA = 8'h2C;  // ','
  localparam logic [ByteW-1:0] CH_ZERO  = 8'h30;  // '0'
  localparam logic [ByteW-1:0] CH_ONE   = 8'h31;  // '1'
  localparam logic [ByteW-1:0] CH_FOUR  = 8'h34;  // '4'
  localparam logic [ByteW-1:0] CH_NINE  = 8'h39;  // '9'

  // Active channel codes
  localparam logic [ActW-1:0] ACT_NONE = 3'd0;
  localparam logic [ActW-1:0] ACT_V1   = 3'd1;
  localparam logic [ActW-1:0] ACT_V3   = 3'd3;

  // Saturation limit of the 4-bit field counters
  localparam logic [FracW-1:0] CNT_MAX = 4'd15;

  typedef logic [ByteW-1:0] byte_t;

endpackage

>>> rtl/channel_value_field_parser_core.sv
`timescale 1ns / 1ps

// Channel value field parser.
// Input channel: one text byte per transfer on in_rx_byte (in_valid / in_stall).
// Output channel: one decoded value per closed V1..V3 field on out_channel,
// out_mantissa, out_frac_digits and out_overflow (out_valid / out_stall).
// The value is out_mantissa / 10^out_frac_digits; out_overflow marks a field
// that offered more than MAX_DIGITS digits (the extra digits are dropped).
// A byte moves into an input register on its transfer and is decoded when
// the output register has room, against the four-byte history and the open
// field state; the closing ',' of a field puts its result in the output
// register as that ',' is decoded, ready to leave when out_stall is low.
// V4 fields and all other bytes produce no result.
// Throughput: one byte per cycle, set by the single decode stage between the
// input and output registers. A held byte is decoded only when the output
// register is empty or its result leaves in the same cycle; while a result
// is stalled the output holds its value, the byte stays in the input
// register and the input stalls.
// Reset (rst_n low, synchronous) clears the history, the field state and
// both valid flags.
module channel_value_field_parser_core #(
  parameter int unsigned MAX_DIGITS = 9
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [cvfp_pkg::ByteW-1:0]    in_rx_byte,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [cvfp_pkg::ChanW-1:0]    out_channel,
  output logic [cvfp_pkg::MantW-1:0]    out_mantissa,
  output logic [cvfp_pkg::FracW-1:0]    out_frac_digits,
  output logic                          out_overflow
);

  localparam logic [4:0] MaxDig = 5'(MAX_DIGITS);

  // Input register
  cvfp_pkg::byte_t                  byte_r;
  logic                             byte_vld_r;

  // Parser state
  cvfp_pkg::byte_t                  hist_r [cvfp_pkg::HistN];
  logic [cvfp_pkg::ActW-1:0]        act_r, act_nxt;
  logic [cvfp_pkg::MantW-1:0]       mant_r, mant_nxt;
  logic [cvfp_pkg::FracW-1:0]       frac_r, frac_nxt;
  logic [cvfp_pkg::FracW-1:0]       dcnt_r, dcnt_nxt;
  logic                             dot_r, dot_nxt;
  logic                             stop_r, stop_nxt;
  logic                             ovf_r, ovf_nxt;

  // Output register
  logic                             out_vld_r;
  logic [cvfp_pkg::ChanW-1:0]       out_chan_r;
  logic [cvfp_pkg::MantW-1:0]       out_mant_r;
  logic [cvfp_pkg::FracW-1:0]       out_frac_r;
  logic                             out_ovf_r;

  logic                             emit;
  logic                             adv;
  logic                             in_xfer;
  logic                             out_xfer;
  logic                             out_free;
  logic                             is_digit;
  logic [cvfp_pkg::MantW-1:0]       mant_x10;

  assign out_xfer = out_vld_r && !out_stall;
  assign out_free = !out_vld_r || !out_stall;
  // decode the held byte when its possible result has room
  assign adv      = byte_vld_r && out_free;
  assign in_stall = byte_vld_r && !out_free;
  assign in_xfer  = in_valid && !in_stall;

  assign is_digit = byte_r inside {[cvfp_pkg::CH_ZERO:cvfp_pkg::CH_NINE]};
  assign mant_x10 = (mant_r << 3) + (mant_r << 1);

  // Field decode for the held byte
  always_comb begin
    act_nxt  = act_r;
    mant_nxt = mant_r;
    frac_nxt = frac_r;
    dcnt_nxt = dcnt_r;
    dot_nxt  = dot_r;
    stop_nxt = stop_r;
    ovf_nxt  = ovf_r;
    emit     = 1'b0;
    if (act_r == cvfp_pkg::ACT_NONE) begin
      if (hist_r[3] == cvfp_pkg::CH_MARK &&
          byte_r inside {[cvfp_pkg::CH_ONE:cvfp_pkg::CH_FOUR]}) begin
        act_nxt = byte_r[cvfp_pkg::ActW-1:0];
      end
    end else if (is_digit) begin
      if (!stop_r) begin
        if ({1'b0, dcnt_r} >= MaxDig) begin
          ovf_nxt = 1'b1;
        end else begin
          mant_nxt = mant_x10 + cvfp_pkg::MantW'(byte_r[3:0]);
          if (dcnt_r != cvfp_pkg::CNT_MAX) dcnt_nxt = dcnt_r + 1'b1;
          if (dot_r && frac_r != cvfp_pkg::CNT_MAX) frac_nxt = frac_r + 1'b1;
        end
      end
    end else if (byte_r == cvfp_pkg::CH_DOT) begin
      if (dot_r) stop_nxt = 1'b1;
      else       dot_nxt  = 1'b1;
    end else if (byte_r == cvfp_pkg::CH_COMMA) begin
      emit     = act_r inside {[cvfp_pkg::ACT_V1:cvfp_pkg::ACT_V3]};
      act_nxt  = cvfp_pkg::ACT_NONE;
      mant_nxt = '0;
      frac_nxt = '0;
      dcnt_nxt = '0;
      dot_nxt  = 1'b0;
      stop_nxt = 1'b0;
      ovf_nxt  = 1'b0;
    end
  end

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byte_vld_r <= 1'b0;
    end else if (in_xfer) begin
      byte_vld_r <= 1'b1;
    end else if (adv) begin
      byte_vld_r <= 1'b0;
    end
    if (in_xfer) byte_r <= in_rx_byte;
  end

  // Parser state and history
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < cvfp_pkg::HistN; i++) hist_r[i] <= '0;
      act_r  <= cvfp_pkg::ACT_NONE;
      mant_r <= '0;
      frac_r <= '0;
      dcnt_r <= '0;
      dot_r  <= 1'b0;
      stop_r <= 1'b0;
      ovf_r  <= 1'b0;
    end else if (adv) begin
      for (int i = cvfp_pkg::HistN - 1; i > 0; i--) hist_r[i] <= hist_r[i-1];
      hist_r[0] <= byte_r;
      act_r  <= act_nxt;
      mant_r <= mant_nxt;
      frac_r <= frac_nxt;
      dcnt_r <= dcnt_nxt;
      dot_r  <= dot_nxt;
      stop_r <= stop_nxt;
      ovf_r  <= ovf_nxt;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (adv && emit) begin
      out_vld_r <= 1'b1;
    end else if (out_xfer) begin
      out_vld_r <= 1'b0;
    end
    if (adv && emit) begin
      out_chan_r <= cvfp_pkg::ChanW'(act_r - cvfp_pkg::ACT_V1);
      out_mant_r <= mant_r;
      out_frac_r <= frac_r;
      out_ovf_r  <= ovf_r;
    end
  end

  assign out_valid       = out_vld_r;
  assign out_channel     = out_chan_r;
  assign out_mantissa    = out_mant_r;
  assign out_frac_digits = out_frac_r;
  assign out_overflow    = out_ovf_r;

endmodule

>>> rtl/cvfp_checker.sv
`timescale 1ns / 1ps

module cvfp_checker #(
  parameter int unsigned MAX_DIGITS = 9
) (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          out_valid,
  input logic                          out_stall,
  input logic [cvfp_pkg::ChanW-1:0]    out_channel,
  input logic [cvfp_pkg::MantW-1:0]    out_mantissa,
  input logic [cvfp_pkg::FracW-1:0]    out_frac_digits,
  input logic                          out_overflow
);

  // fraction digits never exceed the accepted digit count
  localparam logic [4:0] FracLim = (MAX_DIGITS > 15) ? 5'd15 : 5'(MAX_DIGITS);

  // no result directly after reset
  a_reset_clears: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  // a stalled result stays and holds its payload
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_channel) &&
      $stable(out_mantissa) && $stable(out_frac_digits) && $stable(out_overflow))
    else $error("stalled result changed");

  // V4 fields never produce a result
  a_channel: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_channel != 2'd3)
    else $error("result on channel code 3");

  // fraction count bounded by the digit limit
  a_frac: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> {1'b0, out_frac_digits} <= FracLim)
    else $error("fraction digit count above limit");

endmodule

bind channel_value_field_parser_core cvfp_checker #(.MAX_DIGITS(MAX_DIGITS)) u_cvfp_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .out_valid       (out_valid),
  .out_stall       (out_stall),
  .out_channel     (out_channel),
  .out_mantissa    (out_mantissa),
  .out_frac_digits (out_frac_digits),
  .out_overflow    (out_overflow)
);
